// ----- rtl/twcal_pkg.sv -----
package twcal_pkg;

    // Default sizes of the calibration tables.
    localparam int CHANNELS_DEF      = 64;
    localparam int MAX_WALK_BINS_DEF = 32;

    // Field widths of the item and result channels.
    localparam int OP_W      = 2;
    localparam int CHAN_W    = 6;
    localparam int BIN_IDX_W = 5;
    localparam int TIME_W    = 40;
    localparam int TOT_W     = 16;
    localparam int VALUE_W   = 32;
    localparam int CTIME_W   = 41;
    localparam int CTOT_W    = 20;

    // Table entry widths.
    localparam int OFFSET_W = 32;
    localparam int GAIN_W   = 16;
    localparam int WALK_W   = 16;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_HIT    = 2'd0;
    localparam logic [OP_W-1:0] OP_OFFSET = 2'd1;
    localparam logic [OP_W-1:0] OP_GAIN   = 2'd2;
    localparam logic [OP_W-1:0] OP_WALK   = 2'd3;

    // Configuration port.
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam int THM_W   = 16;
    localparam int SCALE_W = 16;
    localparam int NBINS_W = 6;

    localparam logic [1:0] REG_TOT_HALF_MIN = 2'd0;
    localparam logic [1:0] REG_BIN_SCALE    = 2'd1;
    localparam logic [1:0] REG_BINS_IN_USE  = 2'd2;

    localparam logic [THM_W-1:0]   TOT_HALF_MIN_RST = 16'd0;
    localparam logic [SCALE_W-1:0] BIN_SCALE_RST    = 16'd256;
    localparam logic [NBINS_W-1:0] BINS_IN_USE_RST  = 6'd32;

    // Largest calibrated ToT; a clipped result reads this value.
    localparam logic [CTOT_W-1:0] CTOT_MAX = '1;

endpackage

// ----- rtl/tof_hit_time_walk_calibration_unit.sv -----
// A hit item accepted at a clock edge passes stages 1 to 4 and the output register to out_valid.
// Throughput: one item per clock while in_stall is low, table writes and hits mixed freely; the
// walk table memory gives both interpolation neighbors in one access through its two read ports.
// Reset: rst_n (asynchronous, active low) empties the pipeline and loads the configuration
// defaults; the offset, gain and walk tables are not cleared and hold unknown data until written.
module tof_hit_time_walk_calibration_unit #(
    parameter int CHANNELS      = twcal_pkg::CHANNELS_DEF,
    parameter int MAX_WALK_BINS = twcal_pkg::MAX_WALK_BINS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [twcal_pkg::PADDR_W-1:0]         paddr,
    input  logic [twcal_pkg::PDATA_W-1:0]         pwdata,
    output logic [twcal_pkg::PDATA_W-1:0]         prdata,
    output logic                                  pready,

    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [twcal_pkg::OP_W-1:0]            operation,
    input  logic [twcal_pkg::CHAN_W-1:0]          channel,
    input  logic                                  side,
    input  logic [twcal_pkg::BIN_IDX_W-1:0]       bin_index,
    input  logic [twcal_pkg::TIME_W-1:0]          raw_time,
    input  logic [twcal_pkg::TOT_W-1:0]           raw_tot,
    input  logic signed [twcal_pkg::VALUE_W-1:0]  table_value,

    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [twcal_pkg::CHAN_W-1:0]          out_channel,
    output logic                                  out_side,
    output logic signed [twcal_pkg::CTIME_W-1:0]  calibrated_time,
    output logic [twcal_pkg::CTOT_W-1:0]          calibrated_tot,
    output logic                                  tot_saturated
);

    import twcal_pkg::*;

    // Table geometry. Each channel has two readout ends; every end owns an
    // offset, a gain and a row of MAX_WALK_BINS walk entries.
    localparam int ENDS    = 2 * CHANNELS;
    localparam int END_W   = $clog2(ENDS);
    localparam int BIN_W   = $clog2(MAX_WALK_BINS);
    localparam int WDEPTH  = ENDS * MAX_WALK_BINS;
    localparam int WADDR_W = $clog2(WDEPTH);
    localparam int CAL_W   = OFFSET_W + GAIN_W;

    // Arithmetic widths. The bin position is a signed Q18.16 value; the
    // interpolation fraction is only used where it lies within half a bin.
    localparam int POS_W   = 2 * (TOT_W + 1);
    localparam int FRAC_W  = 17;
    localparam int DIFF_W  = WALK_W + 1;
    localparam int PROD_W  = FRAC_W + DIFF_W;
    localparam int RND_W   = PROD_W + 1 - 16;
    localparam int WSUM_W  = RND_W + 1;
    localparam int TMO_W   = TIME_W + 2;
    localparam int T_W     = TMO_W + 1;
    localparam int TOTP_W  = TOT_W + GAIN_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [THM_W-1:0]   thm_reg;
    logic [SCALE_W-1:0] bscale_reg;
    logic [NBINS_W-1:0] nbins_reg;
    logic               cfg_wr;
    logic [1:0]         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thm_reg    <= TOT_HALF_MIN_RST;
            bscale_reg <= BIN_SCALE_RST;
            nbins_reg  <= BINS_IN_USE_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_TOT_HALF_MIN: thm_reg    <= pwdata[THM_W-1:0];
                REG_BIN_SCALE:    bscale_reg <= pwdata[SCALE_W-1:0];
                REG_BINS_IN_USE:  nbins_reg  <= pwdata[NBINS_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_TOT_HALF_MIN: prdata = {{(PDATA_W-THM_W){1'b0}}, thm_reg};
            REG_BIN_SCALE:    prdata = {{(PDATA_W-SCALE_W){1'b0}}, bscale_reg};
            REG_BINS_IN_USE:  prdata = {{(PDATA_W-NBINS_W){1'b0}}, nbins_reg};
            default:          prdata = '0;
        endcase
    end

    // Index of the last walk bin in use. Zero bins in use behaves as one,
    // and a count above the table size behaves as the full table.
    logic [BIN_W-1:0] last_bin;

    always_comb
    begin
        if (nbins_reg == '0)
            last_bin = '0;
        else if (int'(nbins_reg) > MAX_WALK_BINS)
            last_bin = BIN_W'(MAX_WALK_BINS - 1);
        else
            last_bin = BIN_W'(nbins_reg - NBINS_W'(1));
    end

    // ------------------------------------------------------------------
    // Pipeline flow control
    // ------------------------------------------------------------------
    // Every stage loads when it is empty or when the stage after it loads,
    // so bubbles close up and the input keeps flowing while a finished
    // result waits in the output register. The input stalls only when all
    // stages and the output register are full and the output is stalled.
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;
    logic ld1, ld2, ld3, ld4, ld_out;
    logic in_accept;

    assign ld_out    = !out_valid_reg || !out_stall;
    assign ld4       = !s4_valid_reg || ld_out;
    assign ld3       = !s3_valid_reg || ld4;
    assign ld2       = !s2_valid_reg || ld3;
    assign ld1       = !s1_valid_reg || ld2;
    assign in_stall  = !ld1;
    assign in_accept = in_valid && ld1;

    // ------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------
    // Items on channels beyond the table are dropped: writes are ignored
    // and hits give no result. A walk write beyond the row is ignored too.
    logic                 chan_ok;
    logic                 bin_ok;
    logic [END_W-1:0]     in_end;
    logic [WADDR_W-1:0]   in_wbase;
    logic [WADDR_W-1:0]   in_waddr;
    logic signed [TOT_W:0] in_diff;
    logic signed [POS_W-1:0] pos_next;

    assign chan_ok  = int'(channel) < CHANNELS;
    assign bin_ok   = int'(bin_index) < MAX_WALK_BINS;
    assign in_end   = END_W'({channel, side});
    assign in_wbase = WADDR_W'(in_end) * WADDR_W'(MAX_WALK_BINS);
    assign in_waddr = in_wbase + WADDR_W'(bin_index);

    // Bin position (raw_tot - tot_half_minimum) * bin_scale in Q18.16.
    assign in_diff  = $signed({1'b0, raw_tot}) - $signed({1'b0, thm_reg});
    assign pos_next = in_diff * $signed({1'b0, bscale_reg});

    // ------------------------------------------------------------------
    // Offset and gain memory
    // ------------------------------------------------------------------
    // One entry per readout end, offset in the low OFFSET_W bits and gain
    // above it, each written on its own. Table writes take effect at the
    // edge that accepts them, and every hit reads here at its own accept
    // edge, so a hit always sees exactly the writes that came before it.
    logic [CAL_W-1:0] cal_mem [ENDS];
    logic [CAL_W-1:0] cal_rd_reg;

    always_ff @(posedge clk)
    begin
        if (in_accept && chan_ok && (operation == OP_OFFSET))
            cal_mem[in_end][OFFSET_W-1:0] <= table_value;
        if (in_accept && chan_ok && (operation == OP_GAIN))
            cal_mem[in_end][CAL_W-1:OFFSET_W] <= table_value[GAIN_W-1:0];
        if (in_accept)
            cal_rd_reg <= cal_mem[in_end];
    end

    // ------------------------------------------------------------------
    // Stage 1: bin selection and walk table addressing
    // ------------------------------------------------------------------
    logic [CHAN_W-1:0]       s1_chan_reg;
    logic                    s1_side_reg;
    logic [TIME_W-1:0]       s1_time_reg;
    logic [TOT_W-1:0]        s1_tot_reg;
    logic signed [POS_W-1:0] s1_pos_reg;
    logic [WADDR_W-1:0]      s1_wbase_reg;

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            s1_chan_reg  <= channel;
            s1_side_reg  <= side;
            s1_time_reg  <= raw_time;
            s1_tot_reg   <= raw_tot;
            s1_pos_reg   <= pos_next;
            s1_wbase_reg <= in_wbase;
        end
    end

    logic                     s1_neg;
    logic [POS_W-17:0]        s1_ipart;
    logic                     s1_clamp;
    logic [BIN_W-1:0]         s1_bin;
    logic [BIN_W-1:0]         s1_nbr;
    logic                     s1_fhi;
    logic                     s1_up;
    logic                     s1_down;
    logic signed [FRAC_W-1:0] s1_frac;
    logic signed [FRAC_W-1:0] frac_next;
    logic [WADDR_W-1:0]       s1_addr0;
    logic [WADDR_W-1:0]       s1_addr1;
    logic signed [OFFSET_W-1:0] s1_off;
    logic [GAIN_W-1:0]        s1_gain;
    logic signed [TMO_W-1:0]  tmo_next;
    logic [TOTP_W-1:0]        totprod_next;

    // A negative position falls in bin 0; past the last bin in use the
    // bin is clamped. Interpolation runs toward the upper neighbor when
    // the position lies above the bin center and toward the lower one
    // otherwise, never beyond either end of the bins in use. Whenever it
    // runs, the bin was not clamped and the fraction is within half a bin.
    assign s1_neg   = s1_pos_reg[POS_W-1];
    assign s1_ipart = s1_pos_reg[POS_W-1:16];
    assign s1_clamp = !s1_neg && (s1_ipart > (POS_W-16)'(last_bin));
    assign s1_bin   = s1_neg ? '0 : (s1_clamp ? last_bin : BIN_W'(s1_ipart));
    assign s1_fhi   = s1_pos_reg[15:0] > 16'd32768;
    assign s1_up    = !s1_neg && !s1_clamp && s1_fhi && (s1_bin != last_bin);
    assign s1_down  = !s1_neg && !s1_clamp && !s1_fhi && (s1_bin != '0);
    assign s1_frac  = {1'b0, s1_pos_reg[15:0]} - 17'd32768;
    assign frac_next = (s1_up || s1_down) ? s1_frac : '0;

    always_comb
    begin
        if (s1_up)
            s1_nbr = s1_bin + BIN_W'(1);
        else if (s1_down)
            s1_nbr = s1_bin - BIN_W'(1);
        else
            s1_nbr = s1_bin;
    end

    assign s1_addr0 = s1_wbase_reg + WADDR_W'(s1_bin);
    assign s1_addr1 = s1_wbase_reg + WADDR_W'(s1_nbr);

    // Offset subtraction and gain product use the table data read at accept.
    assign s1_off       = cal_rd_reg[OFFSET_W-1:0];
    assign s1_gain      = cal_rd_reg[CAL_W-1:OFFSET_W];
    assign tmo_next     = $signed({2'b00, s1_time_reg}) - s1_off;
    assign totprod_next = s1_tot_reg * s1_gain;

    // ------------------------------------------------------------------
    // Walk memory
    // ------------------------------------------------------------------
    // One write port at the accept edge and two read ports for the bin
    // and its interpolation neighbor. A hit reads while it moves from
    // stage 1 to stage 2. While a hit waits in stage 1 no new item is
    // accepted, and a write accepted at the same edge as the read belongs
    // to a later item, so the read returning the old contents is correct.
    logic [WALK_W-1:0]        walk_mem [WDEPTH];
    logic signed [WALK_W-1:0] s2_w0_reg;
    logic signed [WALK_W-1:0] s2_w1_reg;

    always_ff @(posedge clk)
    begin
        if (in_accept && chan_ok && bin_ok && (operation == OP_WALK))
            walk_mem[in_waddr] <= table_value[WALK_W-1:0];
        if (ld2)
        begin
            s2_w0_reg <= walk_mem[s1_addr0];
            s2_w1_reg <= walk_mem[s1_addr1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: interpolation product and ToT rounding
    // ------------------------------------------------------------------
    logic [CHAN_W-1:0]        s2_chan_reg;
    logic                     s2_side_reg;
    logic signed [TMO_W-1:0]  s2_tmo_reg;
    logic [TOTP_W-1:0]        s2_totprod_reg;
    logic signed [FRAC_W-1:0] s2_frac_reg;
    logic                     s2_down_reg;

    always_ff @(posedge clk)
    begin
        if (ld2)
        begin
            s2_chan_reg    <= s1_chan_reg;
            s2_side_reg    <= s1_side_reg;
            s2_tmo_reg     <= tmo_next;
            s2_totprod_reg <= totprod_next;
            s2_frac_reg    <= frac_next;
            s2_down_reg    <= s1_down;
        end
    end

    logic signed [DIFF_W-1:0] s2_diff;
    logic signed [PROD_W-1:0] prod_next;
    logic [TOTP_W:0]          s2_totrnd;
    logic [TOTP_W-12:0]       s2_totq;
    logic                     sat_next;
    logic [CTOT_W-1:0]        tot_next;

    // The fraction is zero when no interpolation applies, so the product
    // then adds nothing to the walk.
    assign s2_diff   = s2_w1_reg - s2_w0_reg;
    assign prod_next = s2_frac_reg * s2_diff;

    // Calibrated ToT: Q8.8 times Q4.12, rounded half up to Q12.8.
    assign s2_totrnd = {1'b0, s2_totprod_reg} + (TOTP_W+1)'(2048);
    assign s2_totq   = s2_totrnd[TOTP_W:12];
    assign sat_next  = s2_totq[CTOT_W];
    assign tot_next  = sat_next ? CTOT_MAX : s2_totq[CTOT_W-1:0];

    // ------------------------------------------------------------------
    // Stage 3: rounding of the interpolated step and walk value
    // ------------------------------------------------------------------
    logic [CHAN_W-1:0]        s3_chan_reg;
    logic                     s3_side_reg;
    logic signed [TMO_W-1:0]  s3_tmo_reg;
    logic [CTOT_W-1:0]        s3_tot_reg;
    logic                     s3_sat_reg;
    logic signed [WALK_W-1:0] s3_w0_reg;
    logic signed [PROD_W-1:0] s3_prod_reg;
    logic                     s3_down_reg;

    always_ff @(posedge clk)
    begin
        if (ld3)
        begin
            s3_chan_reg <= s2_chan_reg;
            s3_side_reg <= s2_side_reg;
            s3_tmo_reg  <= s2_tmo_reg;
            s3_tot_reg  <= tot_next;
            s3_sat_reg  <= sat_next;
            s3_w0_reg   <= s2_w0_reg;
            s3_prod_reg <= prod_next;
            s3_down_reg <= s2_down_reg;
        end
    end

    logic signed [PROD_W:0]   s3_rsum;
    logic signed [RND_W-1:0]  s3_r;
    logic signed [WSUM_W-1:0] walk_next;

    // Half-up rounding from 2^-16 units: add one half, then floor.
    assign s3_rsum   = s3_prod_reg + (PROD_W+1)'(32768);
    assign s3_r      = s3_rsum[PROD_W:16];
    assign walk_next = s3_down_reg ? (s3_w0_reg - s3_r) : (s3_w0_reg + s3_r);

    // ------------------------------------------------------------------
    // Stage 4: final time and saturation
    // ------------------------------------------------------------------
    logic [CHAN_W-1:0]        s4_chan_reg;
    logic                     s4_side_reg;
    logic signed [TMO_W-1:0]  s4_tmo_reg;
    logic [CTOT_W-1:0]        s4_tot_reg;
    logic                     s4_sat_reg;
    logic signed [WSUM_W-1:0] s4_walk_reg;

    always_ff @(posedge clk)
    begin
        if (ld4)
        begin
            s4_chan_reg <= s3_chan_reg;
            s4_side_reg <= s3_side_reg;
            s4_tmo_reg  <= s3_tmo_reg;
            s4_tot_reg  <= s3_tot_reg;
            s4_sat_reg  <= s3_sat_reg;
            s4_walk_reg <= walk_next;
        end
    end

    logic signed [T_W-1:0]     s4_t;
    logic                      s4_fits;
    logic signed [CTIME_W-1:0] ctime_next;

    // The time fits the result width when the bits above it all repeat
    // the sign; otherwise it is clipped to the nearest end of the range.
    assign s4_t    = s4_tmo_reg - s4_walk_reg;
    assign s4_fits = (s4_t[T_W-1:CTIME_W-1] == '0) || (s4_t[T_W-1:CTIME_W-1] == '1);

    always_comb
    begin
        if (s4_fits)
            ctime_next = s4_t[CTIME_W-1:0];
        else if (s4_t[T_W-1])
            ctime_next = {1'b1, {(CTIME_W-1){1'b0}}};
        else
            ctime_next = {1'b0, {(CTIME_W-1){1'b1}}};
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [CHAN_W-1:0]         out_chan_reg;
    logic                      out_side_reg;
    logic signed [CTIME_W-1:0] out_time_reg;
    logic [CTOT_W-1:0]         out_tot_reg;
    logic                      out_sat_reg;

    always_ff @(posedge clk)
    begin
        if (ld_out)
        begin
            out_chan_reg <= s4_chan_reg;
            out_side_reg <= s4_side_reg;
            out_time_reg <= ctime_next;
            out_tot_reg  <= s4_tot_reg;
            out_sat_reg  <= s4_sat_reg;
        end
    end

    // Only hits on channels within the table enter the pipeline as valid;
    // table writes complete at the accept edge and leave a bubble.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
                s1_valid_reg <= in_valid && chan_ok && (operation == OP_HIT);
            if (ld2)
                s2_valid_reg <= s1_valid_reg;
            if (ld3)
                s3_valid_reg <= s2_valid_reg;
            if (ld4)
                s4_valid_reg <= s3_valid_reg;
            if (ld_out)
                out_valid_reg <= s4_valid_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_channel     = out_chan_reg;
    assign out_side        = out_side_reg;
    assign calibrated_time = out_time_reg;
    assign calibrated_tot  = out_tot_reg;
    assign tot_saturated   = out_sat_reg;

endmodule

// ----- rtl/twcal_checker.sv -----
module twcal_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_stall,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic [twcal_pkg::CHAN_W-1:0]         out_channel,
    input logic signed [twcal_pkg::CTIME_W-1:0] calibrated_time,
    input logic [twcal_pkg::CTOT_W-1:0]         calibrated_tot,
    input logic                                 tot_saturated
);

    import twcal_pkg::*;

    // The input may only back up when a finished result is held waiting.
    a_stall_needs_full_output: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall)
    ) else $error("input stalled while the output was free");

    a_result_held: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid
    ) else $error("stalled result was dropped");

    a_result_stable: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            ($stable(calibrated_time) && $stable(calibrated_tot) && $stable(out_channel))
    ) else $error("stalled result changed");

    // A clipped ToT must read as the largest value.
    a_sat_is_max: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && tot_saturated) |-> (calibrated_tot == CTOT_MAX)
    ) else $error("saturated ToT is not at its maximum");

endmodule

bind tof_hit_time_walk_calibration_unit twcal_checker u_twcal_checker (.*);

// ----- tb/sv/twcal_check_pkg.sv -----
`timescale 1ns / 100ps

package twcal_check_pkg;

    import twcal_pkg::*;

    localparam int END_COUNT = 2 * CHANNELS_DEF;
    localparam int WALK_BINS = MAX_WALK_BINS_DEF;

    localparam longint TIME_HI = 64'sd1099511627775;
    localparam longint TIME_LO = -64'sd1099511627776;

    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic [CHAN_W-1:0]    chan;
        logic                 side;
        logic [BIN_IDX_W-1:0] bin;
        logic [TIME_W-1:0]    rtime;
        logic [TOT_W-1:0]     rtot;
        logic [VALUE_W-1:0]   value;
    } hit_item_t;

    typedef struct packed {
        logic [CHAN_W-1:0]  chan;
        logic               side;
        logic [CTIME_W-1:0] ctime;
        logic [CTOT_W-1:0]  ctot;
        logic               sat;
    } hit_result_t;

    // Mirrors the calibration tables and registers, and keeps the calibrated hits
    // that the block still owes us in arrival order.
    class calibration_checker;

        logic signed [OFFSET_W-1:0] offset_tab [END_COUNT];
        logic [GAIN_W-1:0]          gain_tab [END_COUNT];
        logic signed [WALK_W-1:0]   walk_tab [END_COUNT][WALK_BINS];

        logic [THM_W-1:0]   tot_half_min;
        logic [SCALE_W-1:0] bin_scale;
        logic [NBINS_W-1:0] bins_in_use;

        hit_result_t pending_hits[$];
        int hits_noted;
        int writes_noted;
        int hits_checked;
        int mismatches;

        function new();
            tot_half_min = TOT_HALF_MIN_RST;
            bin_scale    = BIN_SCALE_RST;
            bins_in_use  = BINS_IN_USE_RST;
            hits_noted   = 0;
            writes_noted = 0;
            hits_checked = 0;
            mismatches   = 0;
        endfunction

        function void set_config(logic [1:0] idx, logic [PDATA_W-1:0] value);
            case (idx)
                REG_TOT_HALF_MIN: tot_half_min = value[THM_W-1:0];
                REG_BIN_SCALE:    bin_scale    = value[SCALE_W-1:0];
                REG_BINS_IN_USE:  bins_in_use  = value[NBINS_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [PDATA_W-1:0] config_value(logic [1:0] idx);
            case (idx)
                REG_TOT_HALF_MIN: return PDATA_W'(tot_half_min);
                REG_BIN_SCALE:    return PDATA_W'(bin_scale);
                REG_BINS_IN_USE:  return PDATA_W'(bins_in_use);
                default:          return '0;
            endcase
        endfunction

        // Divide by 2^16 and round half up, without shifting a negative value.
        function longint round_q16(longint v);
            longint t;
            t = v + 32768;
            if (t >= 0)
                return t >>> 16;
            return -((-t + 65535) >>> 16);
        endfunction

        function hit_result_t calibrate(hit_item_t it);
            int e;
            int nb;
            int bin;
            longint unsigned rt;
            longint unsigned g;
            longint unsigned tot;
            longint rtot;
            longint thm;
            longint scl;
            longint pos;
            longint frac;
            longint w_here;
            longint w_next;
            longint walk;
            longint rtm;
            longint off;
            longint t;
            hit_result_t r;

            e  = {it.chan, it.side};
            nb = bins_in_use;
            if (nb < 1)
                nb = 1;
            if (nb > WALK_BINS)
                nb = WALK_BINS;

            rt  = it.rtot;
            g   = gain_tab[e];
            tot = (rt * g + 2048) >> 12;
            r.sat = 1'b0;
            if (tot > CTOT_MAX) begin
                tot   = CTOT_MAX;
                r.sat = 1'b1;
            end

            rtot = it.rtot;
            thm  = tot_half_min;
            scl  = bin_scale;
            pos  = (rtot - thm) * scl;
            if (pos < 0)
                bin = 0;
            else
                bin = int'(pos >>> 16);
            if (bin > nb - 1)
                bin = nb - 1;
            frac = pos - (longint'(bin) << 16) - 32768;

            w_here = walk_tab[e][bin];
            walk   = w_here;
            if (frac > 0) begin
                if (bin < nb - 1) begin
                    w_next = walk_tab[e][bin + 1];
                    walk   = walk + round_q16(frac * (w_next - w_here));
                end
            end else if (bin > 0) begin
                w_next = walk_tab[e][bin - 1];
                walk   = walk - round_q16(frac * (w_next - w_here));
            end

            rtm = it.rtime;
            off = offset_tab[e];
            t   = rtm - off - walk;
            if (t > TIME_HI)
                t = TIME_HI;
            if (t < TIME_LO)
                t = TIME_LO;

            r.chan  = it.chan;
            r.side  = it.side;
            r.ctime = t[CTIME_W-1:0];
            r.ctot  = tot[CTOT_W-1:0];
            return r;
        endfunction

        function void note_item(hit_item_t it);
            int e;
            e = {it.chan, it.side};
            case (it.op)
                OP_HIT:    pending_hits.push_back(calibrate(it));
                OP_OFFSET: offset_tab[e] = it.value;
                OP_GAIN:   gain_tab[e] = it.value[GAIN_W-1:0];
                OP_WALK:   walk_tab[e][it.bin] = it.value[WALK_W-1:0];
                default: ;
            endcase
            if (it.op == OP_HIT)
                hits_noted++;
            else
                writes_noted++;
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_hit(hit_result_t got);
            hit_result_t want;
            if (pending_hits.size() == 0) begin
                $error("calibrated hit on channel %0d side %0d with none pending",
                       got.chan, got.side);
                mismatches++;
                return;
            end
            want = pending_hits.pop_front();
            hits_checked++;
            compare_field("out_channel", 64'(want.chan), 64'(got.chan));
            compare_field("out_side", 64'(want.side), 64'(got.side));
            compare_field("calibrated_time", 64'(want.ctime), 64'(got.ctime));
            compare_field("calibrated_tot", 64'(want.ctot), 64'(got.ctot));
            compare_field("tot_saturated", 64'(want.sat), 64'(got.sat));
        endfunction

        function int outstanding();
            return pending_hits.size();
        endfunction

    endclass

endpackage

// ----- tb/sv/tb_tof_hit_time_walk_calibration_unit.sv -----
`timescale 1ns / 100ps

// Testbench for the time-walk calibration unit. Table load items and hit items are
// pushed through the item channel with random gaps, the result channel is stalled
// at random, and every calibrated hit is compared with the calibration_checker's
// own prediction. The register settings change between phases while the block is
// idle, covering zero and out-of-range bin counts, a zero bin scale and the extremes.
module tb_tof_hit_time_walk_calibration_unit;

    import twcal_pkg::*;
    import twcal_check_pkg::*;

    // Hit results pass the pipeline stages and the output register. Table writes
    // make no result, so drain also lets them settle before any register write.
    localparam int LATENCY     = 5;
    localparam int SETTLE      = LATENCY + 4;
    localparam int HOLD_CYCLES = 250;
    localparam int PHASE_ITEMS = 190;
    localparam int PHASES      = 8;
    localparam int LAST_END    = END_COUNT - 1;

    logic clk;
    logic rst_n = 1'b0;

    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [PADDR_W-1:0]   paddr   = '0;
    logic [PDATA_W-1:0]   pwdata  = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    logic                 in_valid    = 1'b0;
    logic                 in_stall;
    logic [OP_W-1:0]      operation   = OP_HIT;
    logic [CHAN_W-1:0]    channel     = '0;
    logic                 side        = 1'b0;
    logic [BIN_IDX_W-1:0] bin_index   = '0;
    logic [TIME_W-1:0]    raw_time    = '0;
    logic [TOT_W-1:0]     raw_tot     = '0;
    logic signed [VALUE_W-1:0] table_value = '0;

    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [CHAN_W-1:0]    out_channel;
    logic                 out_side;
    logic signed [CTIME_W-1:0] calibrated_time;
    logic [CTOT_W-1:0]    calibrated_tot;
    logic                 tot_saturated;

    calibration_checker book;

    // steady turns the random idling of both sides off; hold_request asks the result
    // side to refuse results for a long hold, whose length HOLD_CYCLES sets.
    bit steady       = 1'b0;
    bit hold_request = 1'b0;

    // Hits only go to ends whose offset, gain and whole walk table have been loaded,
    // since the tables hold unknown data after reset.
    int loaded_ends[$];
    bit end_loaded [END_COUNT];
    int items_sent    = 0;
    int cfg_errors    = 0;
    int settings_used = 0;

    tof_hit_time_walk_calibration_unit dut (
        .clk,
        .rst_n,
        .psel,
        .penable,
        .pwrite,
        .paddr,
        .pwdata,
        .prdata,
        .pready,
        .in_valid,
        .in_stall,
        .operation,
        .channel,
        .side,
        .bin_index,
        .raw_time,
        .raw_tot,
        .table_value,
        .out_valid,
        .out_stall,
        .out_channel,
        .out_side,
        .calibrated_time,
        .calibrated_tot,
        .tot_saturated
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Safety net against a hung handshake.
    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------

    function automatic logic [PADDR_W-1:0] reg_addr(logic [1:0] idx);
        return {idx, 2'b00};
    endfunction

    // Setup cycle, then access cycle; the transfer completes at the edge where
    // pready is seen high. An idle cycle follows so that psel is never lowered and
    // raised again within one time step.
    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(input logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Reads a register back and compares it with the value the checker holds for it.
    task automatic verify_reg(input logic [1:0] idx);
        logic [PDATA_W-1:0] rd;
        apb_read(reg_addr(idx), rd);
        if (rd !== book.config_value(idx)) begin
            $error("register %0d: expected 0x%0h, got 0x%0h", idx, book.config_value(idx), rd);
            cfg_errors++;
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input int value);
        apb_write(reg_addr(idx), PDATA_W'(value));
        book.set_config(idx, PDATA_W'(value));
        verify_reg(idx);
    endtask

    task automatic apply_setup(input int thm, input int scl, input int nbins);
        write_reg(REG_TOT_HALF_MIN, thm);
        write_reg(REG_BIN_SCALE, scl);
        write_reg(REG_BINS_IN_USE, nbins);
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // Item channel
    // ------------------------------------------------------------------

    // Offers one item, with a random number of idle cycles in front of it, and holds
    // it until the block takes it. The checker learns of the item at the accepting edge.
    task automatic send_item(input hit_item_t it);
        while (!steady && $urandom_range(0, 99) < 17) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= it.op;
        channel     <= it.chan;
        side        <= it.side;
        bin_index   <= it.bin;
        raw_time    <= it.rtime;
        raw_tot     <= it.rtot;
        table_value <= it.value;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        book.note_item(it);
        items_sent++;
    endtask

    // Stops offering items and waits until every calibrated hit has come back, then
    // lets any table write still in the pipeline settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (book.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [TIME_W-1:0] pick_time();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        case ($urandom_range(0, 19))
            0: r = '0;
            1: r = '1;
            default: ;
        endcase
        return r[TIME_W-1:0];
    endfunction

    // Half of the ToT values aim at walk bin positions from the minimum to just
    // past the last bin, so that both interpolation directions and the table
    // ends are hit; the rest fall below the minimum, anywhere, or on the extremes.
    function automatic logic [TOT_W-1:0] pick_tot();
        int thm;
        int scl;
        int p;
        int t;
        thm = book.tot_half_min;
        scl = book.bin_scale;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4:
            begin
                if (scl != 0) begin
                    p = $urandom_range(0, 33 * 65536);
                    t = thm + p / scl;
                end else begin
                    t = $urandom_range(0, 65535);
                end
            end
            5, 6:    t = $urandom_range(0, thm);
            7, 8:    t = $urandom_range(0, 65535);
            default: t = $urandom_range(0, 1) ? 65535 : 0;
        endcase
        if (t > 65535)
            t = 65535;
        return t[TOT_W-1:0];
    endfunction

    function automatic hit_item_t make_hit(int e, logic [TOT_W-1:0] tot, logic [TIME_W-1:0] tm);
        hit_item_t it;
        it.op    = OP_HIT;
        it.chan  = e >> 1;
        it.side  = e[0];
        it.bin   = $urandom_range(0, 31);
        it.rtime = tm;
        it.rtot  = tot;
        it.value = $urandom();
        return it;
    endfunction

    function automatic hit_item_t make_write(logic [OP_W-1:0] op, int e, int bin,
                                             logic [VALUE_W-1:0] value);
        hit_item_t it;
        it.op    = op;
        it.chan  = e >> 1;
        it.side  = e[0];
        it.bin   = bin;
        it.rtime = pick_time();
        it.rtot  = $urandom_range(0, 65535);
        it.value = value;
        return it;
    endfunction

    // Loads offset, gain and every walk bin of one channel end. Walk tables are either
    // a smooth ramp, as a real calibration would give, or full-range noise.
    task automatic load_end(input int e);
        int b;
        int base;
        int slope;
        bit smooth;
        logic [VALUE_W-1:0] gain;
        smooth = $urandom_range(0, 1);
        base   = $urandom_range(0, 4000) - 2000;
        slope  = $urandom_range(0, 600) - 300;
        case ($urandom_range(0, 9))
            0:       gain = 0;
            1:       gain = 65535;
            2, 3, 4: gain = $urandom();
            default: gain = $urandom_range(3000, 5200);
        endcase
        send_item(make_write(OP_OFFSET, e, 0,
                             $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 200000) - 100000));
        send_item(make_write(OP_GAIN, e, 0, gain));
        for (b = 0; b < WALK_BINS; b++)
            send_item(make_write(OP_WALK, e, b, smooth ? base + slope * b : $urandom()));
        if (!end_loaded[e]) begin
            end_loaded[e] = 1'b1;
            loaded_ends.push_back(e);
        end
    endtask

    // Random traffic: mostly hits on loaded ends, with single table rewrites, stray
    // writes that may leave an end only partly loaded, and now and then a full reload.
    task automatic run_random(input int count);
        int target;
        int pick;
        int e;
        logic [OP_W-1:0] op;
        target = items_sent + count;
        while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            e    = loaded_ends[$urandom_range(0, loaded_ends.size() - 1)];
            op   = $urandom_range(OP_OFFSET, OP_WALK);
            if (pick < 70)
                send_item(make_hit(e, pick_tot(), pick_time()));
            else if (pick < 80)
                send_item(make_write(op, e, $urandom_range(0, 31), $urandom()));
            else if (pick < 99)
                send_item(make_write(op, $urandom_range(0, LAST_END), $urandom_range(0, 31),
                                     $urandom()));
            else
                load_end($urandom_range(0, LAST_END));
        end
    endtask

    // ------------------------------------------------------------------
    // Result channel
    // ------------------------------------------------------------------

    // Takes results whenever out_stall was low at the edge, and picks the stall for the
    // next cycle: a long hold when asked, none in steady phases, else random.
    initial
    begin : result_sink
        hit_result_t got;
        int hold_left;
        hold_left = 0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall == 1'b0) begin
                got.chan  = out_channel;
                got.side  = out_side;
                got.ctime = calibrated_time;
                got.ctot  = calibrated_tot;
                got.sat   = tot_saturated;
                book.check_hit(got);
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
                out_stall    <= 1'b1;
            end else begin
                out_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < 17);
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin : stimulus
        int phase;
        book = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The registers must come out of reset at their defaults.
        verify_reg(REG_TOT_HALF_MIN);
        verify_reg(REG_BIN_SCALE);
        verify_reg(REG_BINS_IN_USE);
        settings_used = 1;

        // Load the lowest and the highest channel end, then a few at random.
        load_end(0);
        load_end(LAST_END);
        repeat (6) load_end($urandom_range(1, LAST_END - 1));

        // Directed items at the default settings: one bin per ToT unit, 32 bins.
        send_item(make_hit(0, 16'h0000, '0));
        send_item(make_hit(LAST_END, 16'hFFFF, '1));
        // Extreme walk values in the first two bins, then interpolation between them
        // from both sides and exactly at a bin center.
        send_item(make_write(OP_WALK, 0, 0, 32'hFFFF_8000));
        send_item(make_write(OP_WALK, 0, 1, 32'h0000_7FFF));
        send_item(make_hit(0, 16'h0140, pick_time()));
        send_item(make_hit(0, 16'h00C0, pick_time()));
        send_item(make_hit(0, 16'h0180, pick_time()));
        // Only the low half of a walk value is kept; in the last bin there is no
        // neighbor to interpolate toward.
        send_item(make_write(OP_WALK, LAST_END, 31, 32'h7FFF_8000));
        send_item(make_hit(LAST_END, 16'd8136, pick_time()));
        // Most negative offset with the largest time drives the result into saturation.
        send_item(make_write(OP_OFFSET, LAST_END, 0, 32'h8000_0000));
        send_item(make_hit(LAST_END, 16'h0100, '1));
        send_item(make_write(OP_OFFSET, 0, 0, 32'h7FFF_FFFF));
        send_item(make_hit(0, 16'h0000, '0));
        // Gain of zero, full-scale gain and unity gain.
        send_item(make_write(OP_GAIN, 0, 0, 32'h0000_0000));
        send_item(make_hit(0, 16'hFFFF, pick_time()));
        send_item(make_write(OP_GAIN, 0, 0, 32'hFFFF_FFFF));
        send_item(make_hit(0, 16'hFFFF, pick_time()));
        send_item(make_write(OP_GAIN, LAST_END, 0, 32'h0000_1000));
        send_item(make_hit(LAST_END, 16'd12345, pick_time()));

        run_random(PHASE_ITEMS);

        for (phase = 1; phase < PHASES; phase++) begin
            drain();
            case (phase)
                1: apply_setup(0, 0, 0);                  // zero scale, zero bins
                2: apply_setup(65535, 65535, 63);         // every register at its top
                3: apply_setup($urandom_range(0, 1024), 256, 1);
                4: apply_setup($urandom_range(0, 4096), $urandom_range(64, 1024),
                               $urandom_range(2, 32));
                5: apply_setup($urandom_range(0, 2000), 512, $urandom_range(33, 63));
                6: apply_setup($urandom_range(0, 65535), $urandom_range(0, 65535),
                               $urandom_range(0, 63));
                default: apply_setup(0, 1, 32);
            endcase
            steady = (phase == 3);
            // The result side holds off for a long time while items keep coming, so
            // the pipeline fills and the input is stalled.
            if (phase == 2 || phase == 6)
                hold_request = 1'b1;
            if (phase == 4) begin
                run_random(PHASE_ITEMS / 2);
                drain();
                run_random(PHASE_ITEMS / 2);
            end else begin
                run_random(PHASE_ITEMS);
            end
        end
        drain();

        $display("summary: %0d items (%0d hits, %0d table writes), %0d results checked",
                 items_sent, book.hits_noted, book.writes_noted, book.hits_checked);
        $display("summary: %0d register settings, %0d channel ends fully loaded",
                 settings_used, loaded_ends.size());
        if (book.mismatches == 0 && cfg_errors == 0 && book.outstanding() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/twcal_pkg.sv
rtl/tof_hit_time_walk_calibration_unit.sv
rtl/twcal_checker.sv
tb/sv/twcal_check_pkg.sv
tb/sv/tb_tof_hit_time_walk_calibration_unit.sv
